// ===== design/ddlmr_pkg.sv =====
// ----------------------------------------------------------------------------
// ddlmr_pkg: shared types, constants and font for the LED matrix row core
// Holds the default digit count, the glyph height, the queue status and item
// flag structs, the front state encoding and the 8x8 digit font.
// ----------------------------------------------------------------------------
`default_nettype none

package ddlmr_pkg;

	localparam int NUM_DIGITS_DEF = 4;
	localparam int GLYPH_ROWS     = 8;
	localparam int ROW_W          = 3;
	localparam int DEV_OUT_W      = 2;
	localparam int TEMP_W         = 17;
	localparam int DIGIT_W        = 4;
	localparam int PATTERN_W      = 8;

	// Reciprocal of ten scaled by 2^20, rounded down.
	localparam int RECIP_SHIFT    = 20;
	localparam logic [TEMP_W-1:0] RECIP_TEN = 17'd104857;

	typedef struct packed {
		logic tenths;   // point on device 1 rather than device 0
		logic clip;
	} item_flags_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CLASS,
		FS_DIGIT,
		FS_PUSH
	} front_state_t;

	function automatic longint unsigned pow10(input int n);
		longint unsigned acc;
		acc = 64'd1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 64'd10;
		end
		return acc;
	endfunction

	function automatic logic [PATTERN_W-1:0] font_row(input logic [DIGIT_W-1:0] digit,
		input logic [ROW_W-1:0] row);
		logic [8*PATTERN_W-1:0] glyph;
		case (digit)
			4'd0: glyph = 64'h78CC_DCFC_ECCC_7800;
			4'd1: glyph = 64'h3070_3030_3030_FC00;
			4'd2: glyph = 64'h78CC_0C38_60CC_FC00;
			4'd3: glyph = 64'h78CC_0C38_0CCC_7800;
			4'd4: glyph = 64'h1C3C_6CCC_FE0C_1E00;
			4'd5: glyph = 64'hFCC0_F80C_0CCC_7800;
			4'd6: glyph = 64'h3860_C0F8_CCCC_7800;
			4'd7: glyph = 64'hFCCC_0C18_3030_3000;
			4'd8: glyph = 64'h78CC_CC78_CCCC_7800;
			4'd9: glyph = 64'h78CC_CC7C_0C18_7000;
			default: glyph = '0;
		endcase
		// Row 0 sits in the top byte.
		return glyph[(7 - row) * PATTERN_W +: PATTERN_W];
	endfunction

endpackage

`default_nettype wire

// ===== design/ddlmr_queue.sv =====
// ----------------------------------------------------------------------------
// ddlmr_queue: two-entry queue between the converter and the row sequencer
// Holds converted items so that a new value can be converted while the
// previous one is still being written out.
// ----------------------------------------------------------------------------
`default_nettype none

module ddlmr_queue #(
	parameter int DATA_W = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [DATA_W-1:0]       push_data,
	input  logic                    pop,
	output logic [DATA_W-1:0]       pop_data,
	output ddlmr_pkg::queue_status_t status
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign status.empty = (count_q == 2'd0);
	assign status.full  = (count_q == 2'd2);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/ddlmr_front.sv =====
// ----------------------------------------------------------------------------
// ddlmr_front: value classification and decimal digit extraction
// Picks tenths or integer mode, saturates, then peels one decimal digit per
// cycle with a reciprocal multiply and hands the digits to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ddlmr_front #(
	parameter int NUM_DIGITS = ddlmr_pkg::NUM_DIGITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [ddlmr_pkg::TEMP_W-1:0]              temp_tenths,
	output logic                                      busy,
	input  logic                                      queue_full,
	output logic                                      push,
	output logic [NUM_DIGITS*ddlmr_pkg::DIGIT_W-1:0]  push_digits,
	output ddlmr_pkg::item_flags_t                    push_flags
);

	localparam int DIGITS_W = NUM_DIGITS * ddlmr_pkg::DIGIT_W;
	localparam int CNT_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int TW       = ddlmr_pkg::TEMP_W;
	localparam longint unsigned TOP    = ddlmr_pkg::pow10(NUM_DIGITS - 1);
	localparam longint unsigned THRESH = (TOP - 64'd1) * 64'd10;
	localparam longint unsigned LIMIT  = TOP * 64'd10 - 64'd1;

	ddlmr_pkg::front_state_t state_q, state_d;

	logic [TW-1:0]         val_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGITS_W-1:0]   digits_q;
	ddlmr_pkg::item_flags_t flags_q;

	logic [2*TW-1:0]       prod;
	logic [TW-1:0]         q0;
	logic [TW-1:0]         r0;
	logic                  corr;
	logic [TW-1:0]         quot;
	logic [ddlmr_pkg::DIGIT_W-1:0] rem;
	logic                  tenths;
	logic [TW-1:0]         sel;
	logic                  over;
	logic [DIGITS_W+ddlmr_pkg::DIGIT_W-1:0] shifted;
	logic                  last_digit;

	// Divide by ten: the reciprocal estimate is low by at most one.
	assign prod  = val_q * ddlmr_pkg::RECIP_TEN;
	assign q0    = TW'(prod >> ddlmr_pkg::RECIP_SHIFT);
	assign r0    = val_q - ((q0 << 3) + (q0 << 1));
	assign corr  = (r0 >= TW'(10));
	assign quot  = q0 + TW'(corr);
	assign rem   = corr ? ddlmr_pkg::DIGIT_W'(r0 - TW'(10)) : ddlmr_pkg::DIGIT_W'(r0);

	assign tenths     = (64'(val_q) < THRESH);
	assign sel        = tenths ? val_q : quot;
	assign over       = (64'(sel) > LIMIT);
	assign shifted    = {rem, digits_q};
	assign last_digit = (cnt_q == CNT_W'(NUM_DIGITS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddlmr_pkg::FS_IDLE: begin
				if (start) begin
					state_d = ddlmr_pkg::FS_CLASS;
				end
			end
			ddlmr_pkg::FS_CLASS: state_d = ddlmr_pkg::FS_DIGIT;
			ddlmr_pkg::FS_DIGIT: begin
				if (last_digit) begin
					state_d = ddlmr_pkg::FS_PUSH;
				end
			end
			ddlmr_pkg::FS_PUSH: begin
				if (!queue_full) begin
					state_d = ddlmr_pkg::FS_IDLE;
				end
			end
			default: state_d = ddlmr_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != ddlmr_pkg::FS_IDLE);
		push        = (state_q == ddlmr_pkg::FS_PUSH) && !queue_full;
		push_digits = digits_q;
		push_flags  = flags_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddlmr_pkg::FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ddlmr_pkg::FS_CLASS) begin
				cnt_q <= '0;
			end else if (state_q == ddlmr_pkg::FS_DIGIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Digits enter at the top, so the ones digit ends up in the lowest slot.
	always_ff @(posedge clk) begin
		case (state_q)
			ddlmr_pkg::FS_IDLE: begin
				if (start) begin
					val_q <= temp_tenths;
				end
			end
			ddlmr_pkg::FS_CLASS: begin
				val_q         <= over ? TW'(LIMIT) : sel;
				flags_q.tenths <= tenths;
				flags_q.clip   <= over;
			end
			ddlmr_pkg::FS_DIGIT: begin
				val_q    <= quot;
				digits_q <= shifted[DIGITS_W+ddlmr_pkg::DIGIT_W-1:ddlmr_pkg::DIGIT_W];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ddlmr_back.sv =====
// ----------------------------------------------------------------------------
// ddlmr_back: row write sequencer
// Takes one converted item from the queue and writes its glyph rows, row by
// row and within a row from the leftmost device down, one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddlmr_back #(
	parameter int NUM_DIGITS = ddlmr_pkg::NUM_DIGITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  ddlmr_pkg::queue_status_t                  queue_status,
	input  logic [NUM_DIGITS*ddlmr_pkg::DIGIT_W-1:0]  item_digits,
	input  ddlmr_pkg::item_flags_t                    item_flags,
	output logic                                      pop,
	output logic                                      strobe,
	output logic [ddlmr_pkg::DEV_OUT_W-1:0]           device_index,
	output logic [ddlmr_pkg::ROW_W-1:0]               row_index,
	output logic [ddlmr_pkg::PATTERN_W-1:0]           row_pattern,
	output logic                                      clipped,
	output logic                                      last_row
);

	localparam int DIGITS_W = NUM_DIGITS * ddlmr_pkg::DIGIT_W;
	localparam int DEV_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [ddlmr_pkg::ROW_W-1:0] LAST_ROW = ddlmr_pkg::ROW_W'(ddlmr_pkg::GLYPH_ROWS - 1);

	logic                   active_q;
	logic [ddlmr_pkg::ROW_W-1:0] row_q;
	logic [DEV_W-1:0]       dev_q;
	logic [DIGITS_W-1:0]    digits_q;
	ddlmr_pkg::item_flags_t flags_q;

	logic                   strobe_q;
	logic [ddlmr_pkg::DEV_OUT_W-1:0] device_q;
	logic [ddlmr_pkg::ROW_W-1:0]     row_out_q;
	logic [ddlmr_pkg::PATTERN_W-1:0] pattern_q;
	logic                   clipped_q;
	logic                   last_q;

	logic                   last_beat;
	logic [ddlmr_pkg::DIGIT_W-1:0]   cur_digit;
	logic                   point_here;
	logic [ddlmr_pkg::PATTERN_W-1:0] pattern_d;

	assign last_beat  = active_q && (row_q == LAST_ROW) && (dev_q == '0);
	assign pop        = (!active_q || last_beat) && !queue_status.empty;
	assign cur_digit  = digits_q[dev_q * ddlmr_pkg::DIGIT_W +: ddlmr_pkg::DIGIT_W];
	assign point_here = (row_q == LAST_ROW) && (dev_q == DEV_W'(flags_q.tenths));
	assign pattern_d  = ddlmr_pkg::font_row(cur_digit, row_q)
		| ddlmr_pkg::PATTERN_W'(point_here);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
			row_q    <= '0;
			dev_q    <= '0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				row_q    <= '0;
				dev_q    <= DEV_W'(NUM_DIGITS - 1);
			end else if (last_beat) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (dev_q == '0) begin
					dev_q <= DEV_W'(NUM_DIGITS - 1);
					row_q <= row_q + ddlmr_pkg::ROW_W'(1);
				end else begin
					dev_q <= dev_q - DEV_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digits_q <= item_digits;
			flags_q  <= item_flags;
		end
		if (active_q) begin
			device_q  <= ddlmr_pkg::DEV_OUT_W'(dev_q);
			row_out_q <= row_q;
			pattern_q <= pattern_d;
			clipped_q <= flags_q.clip;
			last_q    <= last_beat;
		end
	end

	assign strobe       = strobe_q;
	assign device_index = device_q;
	assign row_index    = row_out_q;
	assign row_pattern  = pattern_q;
	assign clipped      = clipped_q;
	assign last_row     = last_q;

endmodule

`default_nettype wire

// ===== design/decimal_digit_led_matrix_rows_core.sv =====
// ----------------------------------------------------------------------------
// decimal_digit_led_matrix_rows_core: temperature to LED matrix row writes
// Converts a temperature in tenths of a degree to decimal glyph row writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive temp_tenths and raise start; the value is taken at the clock
//   edge where start is high and busy is low. busy is high after each
//   accepted value while the converter runs, and longer if the two-entry
//   queue in front of the row sequencer is full.
//   Output: each row write is one beat on device_index, row_index,
//   row_pattern, clipped and last_row, marked by strobe for one cycle; the
//   receiver takes every beat and cannot stall the block.
//   Beats: each value gives 8 * NUM_DIGITS beats (32 for four digits), one
//   per cycle, back to back across values when the next value is queued.
//   Pacing: values are paced by the row sequencer writing one row beat per
//   cycle; the converter is faster and runs ahead while beats are written.
//   Reset: arst_n clears the converter, queue and sequencer; no beats are
//   produced until a new value is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_led_matrix_rows_core #(
	parameter int NUM_DIGITS = ddlmr_pkg::NUM_DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [ddlmr_pkg::TEMP_W-1:0]         temp_tenths,
	output logic                                 strobe,
	output logic [ddlmr_pkg::DEV_OUT_W-1:0]      device_index,
	output logic [ddlmr_pkg::ROW_W-1:0]          row_index,
	output logic [ddlmr_pkg::PATTERN_W-1:0]      row_pattern,
	output logic                                 clipped,
	output logic                                 last_row
);

	localparam int DIGITS_W = NUM_DIGITS * ddlmr_pkg::DIGIT_W;
	localparam int FLAGS_W  = $bits(ddlmr_pkg::item_flags_t);
	localparam int ENTRY_W  = DIGITS_W + FLAGS_W;

	logic                     push;
	logic [DIGITS_W-1:0]      push_digits;
	ddlmr_pkg::item_flags_t   push_flags;
	logic                     pop;
	logic [ENTRY_W-1:0]       pop_data;
	ddlmr_pkg::queue_status_t queue_status;
	ddlmr_pkg::item_flags_t   pop_flags;

	ddlmr_front #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.temp_tenths(temp_tenths),
		.busy       (busy),
		.queue_full (queue_status.full),
		.push       (push),
		.push_digits(push_digits),
		.push_flags (push_flags)
	);

	ddlmr_queue #(
		.DATA_W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_flags, push_digits}),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (queue_status)
	);

	assign pop_flags = pop_data[ENTRY_W-1:DIGITS_W];

	ddlmr_back #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_status(queue_status),
		.item_digits (pop_data[DIGITS_W-1:0]),
		.item_flags  (pop_flags),
		.pop         (pop),
		.strobe      (strobe),
		.device_index(device_index),
		.row_index   (row_index),
		.row_pattern (row_pattern),
		.clipped     (clipped),
		.last_row    (last_row)
	);

`ifndef SYNTHESIS
	// The final beat of a value is always the bottom row of the rightmost device.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_row |-> (device_index == '0) && (row_index == 3'd7))
		else $error("last_row raised away from the final row write");

	// An accepted value keeps the converter busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("converter not busy after accepting a value");

	// Row writes of one value come out without gaps.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_row |=> strobe)
		else $error("gap inside the row writes of one value");
`endif

endmodule

`default_nettype wire
